/* rtl/bem_pkg.sv */
// ----------------------------------------------------------------------------
// bem_pkg: shared types, constants and functions for the binary edge marker
// Line geometry, job descriptor passed from the row store to the sequencer,
// and the edge decision over a three by three window.
// ----------------------------------------------------------------------------
`default_nettype none

package bem_pkg;

    // geometry and port widths
    localparam int MAX_SIDE = 32;
    localparam int SIDE_W   = 6;
    localparam int COORD_W  = 5;
    localparam int ROWS     = 3;
    localparam int PH_W     = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);
    localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    // ring phases of the three line buffers
    localparam logic [PH_W-1:0] PH_0 = PH_W'(0);
    localparam logic [PH_W-1:0] PH_1 = PH_W'(1);
    localparam logic [PH_W-1:0] PH_2 = PH_W'(2);

    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [PH_W-1:0]     t_phase;
    typedef logic [MAX_SIDE-1:0] t_line;

    // span of pixels to report: start cursor, its line phase, last position
    typedef struct packed {
        t_coord i;
        t_coord j;
        t_phase ph;
        t_coord ei;
        t_coord ej;
    } t_job;

    // position of the reported pixel relative to the image border
    typedef struct packed {
        logic has_up;
        logic last_row;
        logic below_last;
        logic has_left;
        logic last_col;
        logic left_of_last;
    } t_flags;

    function automatic t_phase ph_inc(input t_phase p);
        return (p == PH_2) ? PH_0 : t_phase'(p + PH_1);
    endfunction

    function automatic t_phase ph_dec(input t_phase p);
        return (p == PH_0) ? PH_2 : t_phase'(p - PH_1);
    endfunction

    // three pixels not all equal
    function automatic logic mixed3(input logic a, input logic b, input logic c);
        return !((a == b) && (b == c));
    endfunction

    // window bits: [0] left, [1] centre, [2] right; rows u above, m own, d below
    function automatic logic edge_fn(input logic [2:0] u, input logic [2:0] m,
                                     input logic [2:0] d, input t_flags f);
        logic [2:0] v;
        logic       hb_m;
        logic       hb_u;
        logic       hb_d;
        logic       any;
        v    = f.last_row ? u : d;
        hb_m = f.last_col ? m[0] : m[2];
        hb_u = f.last_col ? u[0] : u[2];
        hb_d = f.last_col ? d[0] : d[2];
        any  = mixed3(m[1], v[1], hb_m)
             | (f.has_up       & mixed3(u[1], m[1], hb_u))
             | (f.below_last   & mixed3(d[1], m[1], hb_d))
             | (f.has_left     & mixed3(m[0], v[0], m[1]))
             | (f.left_of_last & mixed3(m[2], v[2], m[1]));
        return m[1] & any;
    endfunction

endpackage

`default_nettype wire

/* rtl/bem_cfg.sv */
// ----------------------------------------------------------------------------
// bem_cfg: configuration register file
// Holds the image side written over the APB-style port, its clamped working
// value, and flags a frame restart on every write to it.
// ----------------------------------------------------------------------------
`default_nettype none

module bem_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bem_pkg::ADDR_W-1:0]  paddr,
    input  logic [bem_pkg::DATA_W-1:0]  pwdata,
    output logic [bem_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [bem_pkg::SIDE_W-1:0]  o_side,
    output logic                        o_restart
);
    import bem_pkg::*;

    localparam logic REG_SIDE = 1'b0;

    logic              wr_side;
    logic [SIDE_W-1:0] wdata_side;
    logic [SIDE_W-1:0] n_eff;
    logic [SIDE_W-1:0] r_side;
    logic [SIDE_W-1:0] r_eff;

    // write strobe on the access phase
    assign wr_side    = psel & penable & pwrite & (paddr[ADDR_W-1] == REG_SIDE);
    assign wdata_side = pwdata[SIDE_W-1:0];

    // clamp side into the supported range
    always_comb begin
        priority if (wdata_side < SIDE_MIN) begin
            n_eff = SIDE_MIN;
        end else if (wdata_side > SIDE_MAX) begin
            n_eff = SIDE_MAX;
        end else begin
            n_eff = wdata_side;
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
            r_eff  <= SIDE_RESET;
        end else if (wr_side) begin
            r_side <= wdata_side;
            r_eff  <= n_eff;
        end
    end

    // read back and status
    assign prdata    = (paddr[ADDR_W-1] == REG_SIDE) ?
                       {{(DATA_W-SIDE_W){1'b0}}, r_side} : '0;
    assign pready    = 1'b1;
    assign o_side    = r_eff;
    assign o_restart = wr_side;

endmodule

`default_nettype wire

/* rtl/bem_rows.sv */
// ----------------------------------------------------------------------------
// bem_rows: raster position and line buffers
// Tracks the position of the next pixel, writes each accepted pixel into the
// ring of three line buffers and hands the span of pixels to report to the
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bem_rows (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_restart,
    input  logic [bem_pkg::SIDE_W-1:0]                   i_side,
    input  logic                                         i_accept,
    input  logic                                         i_pixel,
    output logic [bem_pkg::ROWS-1:0][bem_pkg::MAX_SIDE-1:0] o_rows,
    output logic                                         o_job_valid,
    output bem_pkg::t_job                                o_job
);
    import bem_pkg::*;

    t_coord            r_row;
    t_coord            r_col;
    t_phase            r_ph;
    t_line [ROWS-1:0]  r_lines;
    logic [SIDE_W-1:0] nm1;
    logic              col_last;
    logic              row_last;

    // border of the current position
    assign nm1      = i_side - SIDE_W'(1);
    assign col_last = ({1'b0, r_col} == nm1);
    assign row_last = ({1'b0, r_row} == nm1);

    // position counters, restart on a side write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_ph  <= PH_0;
        end else if (i_restart) begin
            r_row <= '0;
            r_col <= '0;
            r_ph  <= PH_0;
        end else if (i_accept) begin
            if (col_last) begin
                r_col <= '0;
                if (row_last) begin
                    r_row <= '0;
                    r_ph  <= PH_0;
                end else begin
                    r_row <= r_row + COORD_W'(1);
                    r_ph  <= ph_inc(r_ph);
                end
            end else begin
                r_col <= r_col + COORD_W'(1);
            end
        end
    end

    // line buffer write, one pixel per beat
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_lines[r_ph][r_col] <= i_pixel;
        end
    end

    assign o_rows = r_lines;

    // span to report: the pixel up and left, the rest of the line above at
    // its end, and the whole last line on the final pixel
    assign o_job_valid = i_accept && (r_row != '0) && (r_col != '0);
    assign o_job.i     = r_row - COORD_W'(1);
    assign o_job.j     = r_col - COORD_W'(1);
    assign o_job.ph    = ph_dec(r_ph);
    assign o_job.ei    = (col_last && row_last) ? r_row : r_row - COORD_W'(1);
    assign o_job.ej    = col_last ? r_col : r_col - COORD_W'(1);

    // position always inside the image
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < i_side) && ({1'b0, r_row} < i_side))
        else $error("position outside image");

endmodule

`default_nettype wire

/* rtl/bem_seq.sv */
// ----------------------------------------------------------------------------
// bem_seq: report sequencer and edge evaluation
// Walks a cursor over the span of pixels to report in raster order, reads the
// three by three window from the line buffers and loads one result a cycle
// into the output register while that register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module bem_seq (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic [bem_pkg::SIDE_W-1:0]                   i_side,
    input  logic [bem_pkg::ROWS-1:0][bem_pkg::MAX_SIDE-1:0] i_rows,
    input  logic                                         i_job_valid,
    input  bem_pkg::t_job                                i_job,
    output logic                                         o_free,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output logic                                         o_edge_res,
    output logic [bem_pkg::COORD_W-1:0]                  o_out_row,
    output logic [bem_pkg::COORD_W-1:0]                  o_out_col,
    output logic                                         o_frame_done
);
    import bem_pkg::*;

    logic              r_busy;
    t_coord            r_i;
    t_coord            r_j;
    t_phase            r_ph;
    t_coord            r_ei;
    t_coord            r_ej;
    logic              r_ovalid;
    logic              r_edge;
    t_coord            r_orow;
    t_coord            r_ocol;
    logic              r_done;

    logic              take;
    logic              step;
    logic              at_end;
    logic [SIDE_W-1:0] nm1;
    logic [SIDE_W-1:0] nm2;
    t_flags            flags;
    t_line             line_u;
    t_line             line_m;
    t_line             line_d;
    t_coord            jl;
    t_coord            jr;
    logic [2:0]        win_u;
    logic [2:0]        win_m;
    logic [2:0]        win_d;
    logic              edge_bit;

    // handshake of the cursor against the output register
    assign take   = !r_ovalid || i_ready;
    assign step   = r_busy && take;
    assign at_end = (r_i == r_ei) && (r_j == r_ej);
    assign o_free = !r_busy || (at_end && take);

    // border flags of the cursor
    assign nm1 = i_side - SIDE_W'(1);
    assign nm2 = i_side - SIDE_W'(2);
    assign flags.has_up       = (r_i != '0);
    assign flags.last_row     = ({1'b0, r_i} == nm1);
    assign flags.below_last   = ({1'b0, r_i} == nm2);
    assign flags.has_left     = (r_j != '0);
    assign flags.last_col     = ({1'b0, r_j} == nm1);
    assign flags.left_of_last = ({1'b0, r_j} == nm2);

    // pick the lines above, at and below the cursor row from the ring
    always_comb begin
        unique case (r_ph)
            PH_0: begin
                line_m = i_rows[0];
                line_u = i_rows[2];
                line_d = i_rows[1];
            end
            PH_1: begin
                line_m = i_rows[1];
                line_u = i_rows[0];
                line_d = i_rows[2];
            end
            default: begin
                line_m = i_rows[2];
                line_u = i_rows[1];
                line_d = i_rows[0];
            end
        endcase
    end

    // three columns around the cursor
    assign jl    = r_j - COORD_W'(1);
    assign jr    = r_j + COORD_W'(1);
    assign win_u = {line_u[jr], line_u[r_j], line_u[jl]};
    assign win_m = {line_m[jr], line_m[r_j], line_m[jl]};
    assign win_d = {line_d[jr], line_d[r_j], line_d[jl]};

    assign edge_bit = edge_fn(win_u, win_m, win_d, flags);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_ovalid <= r_busy;
            end
            if (o_free) begin
                r_busy <= i_job_valid;
            end
        end
    end

    // cursor and result payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_edge <= edge_bit;
            r_orow <= r_i;
            r_ocol <= r_j;
            r_done <= flags.last_row && flags.last_col;
        end
        priority if (o_free && i_job_valid) begin
            r_i  <= i_job.i;
            r_j  <= i_job.j;
            r_ph <= i_job.ph;
            r_ei <= i_job.ei;
            r_ej <= i_job.ej;
        end else if (step && !at_end) begin
            if (flags.last_col) begin
                r_j  <= '0;
                r_i  <= r_i + COORD_W'(1);
                r_ph <= ph_inc(r_ph);
            end else begin
                r_j  <= jr;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_edge_res   = r_edge;
    assign o_out_row    = r_orow;
    assign o_out_col    = r_ocol;
    assign o_frame_done = r_done;

    // a new span only arrives when the cursor can take it
    a_job_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> o_free)
        else $error("span offered while cursor busy");

    // the cursor never runs past the end of its span
    a_cursor_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_i < r_ei) || ((r_i == r_ei) && (r_j <= r_ej))))
        else $error("cursor beyond end of span");

    // the last result of a span frees the cursor unless a new span follows
    a_span_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && at_end && !i_job_valid) |=> (!r_busy && o_valid))
        else $error("cursor still busy after last result");

endmodule

`default_nettype wire

/* rtl/binary_edge_marker.sv */
// ----------------------------------------------------------------------------
// binary_edge_marker: boundary marking on a square binary image
// Takes pixels in raster order, keeps three line buffers and reports each
// pixel once its neighbours are in, marking 1 pixels on a mixed border.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  ----------+-------------------+---------------------------------------------
//  pixel in  | i_valid / o_ready | i_pixel
//  result    | o_valid / i_ready | o_edge_res, o_out_row, o_out_col,
//            |                   | o_frame_done
//  config    | psel / penable    | paddr, pwrite, pwdata, prdata, pready
//
//  one beat in per cycle while each pixel reports at most one result and i_ready is
//  high; the last pixel of a line reports two and holds the input until both are loaded
//  the last pixel of the image reports side+2 results
//  a pixel beat loads the cursor registers, which then load the output register; the report
//  cursor in bem_seq, one result per cycle while i_ready allows, sets the rate
//  synchronous active-low reset clears position, cursor busy and output valid
//  a stall on i_ready holds the output register and then the input
//
`default_nettype none

module binary_edge_marker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bem_pkg::ADDR_W-1:0]  paddr,
    input  logic [bem_pkg::DATA_W-1:0]  pwdata,
    output logic [bem_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_edge_res,
    output logic [bem_pkg::COORD_W-1:0] o_out_row,
    output logic [bem_pkg::COORD_W-1:0] o_out_col,
    output logic                        o_frame_done
);
    import bem_pkg::*;

    logic [SIDE_W-1:0]             side;
    logic                          restart;
    logic                          accept;
    logic                          seq_free;
    logic [ROWS-1:0][MAX_SIDE-1:0] rows;
    logic                          job_valid;
    t_job                          job;

    // pixel beat
    assign accept  = i_valid && seq_free;
    assign o_ready = seq_free;

    // configuration registers
    bem_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_side    (side),
        .o_restart (restart)
    );

    // position and line buffers
    bem_rows u_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_side      (side),
        .i_accept    (accept),
        .i_pixel     (i_pixel),
        .o_rows      (rows),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // report cursor and output register
    bem_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_side       (side),
        .i_rows       (rows),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_free       (seq_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_edge_res   (o_edge_res),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_done (o_frame_done)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_edge_marker
// Streams binary images in raster order through the pixel channel, predicts
// each reported pixel (edge mark, position, frame end) with an in-bench model
// of the three line buffers and checks every result beat in order. The image
// side is rewritten over the run, covering the clamped extremes and aborted
// frames. Both channels idle in random bursts, with one long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bem_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_SIDE  = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_W'(4);
    localparam int RANDOM_ITEMS = 250;
    localparam int SETTLE_CYC   = 40;
    localparam int HOLD_CYC     = 300;
    localparam int LIMIT_CYC    = 200000;
    localparam int MAX_SHOWN    = 10;

    typedef enum int {
        PAT_NOISE,
        PAT_ZERO,
        PAT_ONE,
        PAT_CHECK,
        PAT_BLOB,
        PAT_SPARSE
    } t_pattern;

    // one reported pixel
    typedef struct packed {
        logic   mark;
        t_coord row;
        t_coord col;
        logic   done;
    } t_mark;

    // clock, reset and block inputs, all known from time zero
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic                i_pixel = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_edge_res;
    t_coord              o_out_row;
    t_coord              o_out_col;
    logic                o_frame_done;

    // bench state
    logic  pixels_pending [$];
    t_mark marks_due [$];
    bit    pix_beat  = 1'b0;
    bit    quiet     = 1'b0;
    bit    hold_req  = 1'b0;
    bit    hold_on   = 1'b0;
    int    idle_pct  = 0;
    int    send_gap  = 0;
    int    rdy_gap   = 0;
    int    cycles    = 0;
    int    errors    = 0;
    int    n_beats   = 0;
    int    n_marks   = 0;
    int    n_aborts  = 0;
    int    items_sent = 0;

    // line buffer model
    logic [MAX_SIDE-1:0] img_line [3];
    int unsigned         cur_row;
    int unsigned         cur_col;
    logic [SIDE_W-1:0]   side_reg;

    always #5 i_clk = ~i_clk;

    binary_edge_marker u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_edge_res   (o_edge_res),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_done (o_frame_done)
    );

    // side register as the block uses it
    function automatic int unsigned side_in_use(input logic [SIDE_W-1:0] s);
        if (s < SIDE_MIN) return 32'(SIDE_MIN);
        if (s > SIDE_MAX) return 32'(SIDE_MAX);
        return 32'(s);
    endfunction

    function automatic logic pix_at(input int unsigned a, input int unsigned b);
        return img_line[a % 3][b];
    endfunction

    // triple anchored at (a,b): itself, below or above, right or left
    function automatic logic triple_mixed(input int unsigned a, input int unsigned b,
                                          input int unsigned n);
        int unsigned va;
        int unsigned hb;
        int          sum;
        va  = (a == n - 1) ? a - 1 : a + 1;
        hb  = (b == n - 1) ? b - 1 : b + 1;
        sum = int'(pix_at(a, b)) + int'(pix_at(va, b)) + int'(pix_at(a, hb));
        return (sum > 0) && (sum < 3);
    endfunction

    // a 1 pixel on any mixed triple that contains it
    function automatic logic is_marked(input int unsigned i, input int unsigned j,
                                       input int unsigned n);
        logic m;
        if (!pix_at(i, j)) return 1'b0;
        m = triple_mixed(i, j, n);
        if (i >= 1)     m = m | triple_mixed(i - 1, j, n);
        if (i + 1 == n - 1) m = m | triple_mixed(i + 1, j, n);
        if (j >= 1)     m = m | triple_mixed(i, j - 1, n);
        if (j + 1 == n - 1) m = m | triple_mixed(i, j + 1, n);
        return m;
    endfunction

    function automatic void queue_mark(input int unsigned i, input int unsigned j,
                                       input int unsigned n, input logic done);
        t_mark m;
        m.mark = is_marked(i, j, n);
        m.row  = COORD_W'(i);
        m.col  = COORD_W'(j);
        m.done = done;
        marks_due.push_back(m);
    endfunction

    // store one pixel beat and queue the pixels it completes
    function automatic void predict_marks(input logic px);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        n = side_in_use(side_reg);
        r = cur_row;
        c = cur_col;
        if (r >= n) r = 0;
        if (c >= n) c = 0;
        img_line[r % 3][c] = px;
        if (r >= 1 && c >= 1)     queue_mark(r - 1, c - 1, n, 1'b0);
        if (r >= 1 && c == n - 1) queue_mark(r - 1, n - 1, n, 1'b0);
        if (r == n - 1 && c == n - 1) begin
            for (int unsigned j = 0; j < n; j++)
                queue_mark(n - 1, j, n, j == n - 1);
        end
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    // pixel driver: new beat offered at the falling edge
    always @(negedge i_clk) begin : pixel_drv
        logic nv;
        logic np;
        nv = i_valid;
        np = i_pixel;
        if (!i_valid || pix_beat) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!quiet && $urandom_range(99) < idle_pct) begin
                send_gap = $urandom_range(11);
            end else if (i_rst_n && pixels_pending.size() > 0) begin
                nv = 1'b1;
                np = pixels_pending.pop_front();
            end
        end
        i_valid <= nv;
        i_pixel <= np;
    end

    // result back-pressure, random bursts plus the long hold
    always @(negedge i_clk) begin : ready_drv
        logic nr;
        nr = 1'b1;
        if (rdy_gap > 0) begin
            rdy_gap--;
            nr = 1'b0;
        end else if (!quiet && $urandom_range(99) < idle_pct) begin
            rdy_gap = $urandom_range(11);
            nr = 1'b0;
        end
        if (hold_on) nr = 1'b0;
        i_ready <= nr;
    end

    // long output hold while the sender keeps offering
    initial begin : long_hold
        wait (hold_req);
        hold_on = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_on = 1'b0;
    end

    // monitor: predict on pixel beats, check result beats, watchdog
    always @(posedge i_clk) begin : monitor
        t_mark want;
        cycles++;
        pix_beat = i_rst_n && i_valid && o_ready;
        if (pix_beat) begin
            predict_marks(i_pixel);
            n_beats++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_marks++;
            if (marks_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("unexpected result beat: mark=%0b row=%0d col=%0d done=%0b",
                             o_edge_res, o_out_row, o_out_col, o_frame_done);
            end else begin
                want = marks_due.pop_front();
                if (o_edge_res !== want.mark || o_out_row !== want.row ||
                    o_out_col !== want.col || o_frame_done !== want.done) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("mismatch: want mark=%0b row=%0d col=%0d done=%0b, %s",
                                 want.mark, want.row, want.col, want.done,
                                 $sformatf("got mark=%0b row=%0d col=%0d done=%0b",
                                           o_edge_res, o_out_row, o_out_col,
                                           o_frame_done));
                end
            end
        end
        if (cycles >= LIMIT_CYC) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycles, marks_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // wait until all pixels are in, all results out, and the block is quiet
    task automatic settle();
        while (pixels_pending.size() != 0 || i_valid) @(posedge i_clk);
        while (marks_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // two-phase register write, only once the block is idle
    task automatic cfg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        settle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (a == ADDR_SIDE) begin
            side_reg = d[SIDE_W-1:0];
            cur_row  = 0;
            cur_col  = 0;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] w, input int cnt);
        for (int k = 0; k < cnt; k++) pixels_pending.push_back(w[k]);
        items_sent += cnt;
    endtask

    // first cnt pixels of an n by n image in the given pattern
    task automatic push_frame(input int unsigned n, input int unsigned cnt,
                              input t_pattern pat);
        int unsigned r;
        int unsigned c;
        int unsigned r0;
        int unsigned r1;
        int unsigned c0;
        int unsigned c1;
        logic        p;
        r0 = $urandom_range(n - 1);
        r1 = $urandom_range(n - 1, r0);
        c0 = $urandom_range(n - 1);
        c1 = $urandom_range(n - 1, c0);
        for (int unsigned k = 0; k < cnt; k++) begin
            r = k / n;
            c = k % n;
            case (pat)
                PAT_ZERO:   p = 1'b0;
                PAT_ONE:    p = 1'b1;
                PAT_CHECK:  p = 1'((r + c) % 2);
                PAT_SPARSE: p = ($urandom_range(7) == 0);
                PAT_BLOB:   p = (r >= r0 && r <= r1 && c >= c0 && c <= c1)
                              ^ ($urandom_range(15) == 0);
                default:    p = 1'($urandom_range(1));
            endcase
            pixels_pending.push_back(p);
        end
        items_sent += cnt;
        if (cnt < n * n) n_aborts++;
    endtask

    initial begin : stimulus
        int unsigned sv;
        int unsigned n;
        int unsigned cnt;
        int unsigned reps;
        int unsigned sel;
        int          target;
        int          loops;
        bit          hold_now;
        img_line[0] = '0;
        img_line[1] = '0;
        img_line[2] = '0;
        side_reg    = SIDE_RESET;
        cur_row     = 0;
        cur_col     = 0;
        loops       = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset side: first rows of a full-size image
        push_frame(MAX_SIDE, MAX_SIDE + 4, PAT_NOISE);

        // smallest image, flat then corner pattern, two frames back to back
        cfg_write(ADDR_SIDE, DATA_W'(2));
        push_word(32'b1111, 4);
        push_word(32'b1001, 4);
        // checkerboard, every triple mixed
        cfg_write(ADDR_SIDE, DATA_W'(3));
        push_frame(3, 9, PAT_CHECK);
        // frame cut short by a side write, then side below range
        cfg_write(ADDR_SIDE, DATA_W'(3));
        push_word(32'b0110, 4);
        cfg_write(ADDR_SIDE, {26'h3ff_ffff, SIDE_W'(0)});
        push_word(32'b1110, 4);

        // random images, mostly small, some cut short, some large and partial
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            sel = $urandom_range(99);
            if (sel < 60)      sv = $urandom_range(6, 2);
            else if (sel < 80) sv = $urandom_range(12, 7);
            else if (sel < 88) sv = $urandom_range(31, 13);
            else if (sel < 94) sv = $urandom_range(1, 0);
            else               sv = $urandom_range(63, 33);
            reps = ($urandom_range(3) == 0) ? 2 : 1;
            hold_now = !hold_req && loops == 2;
            if (loops == 0) begin
                sv   = 4;
                reps = 2;
            end
            if (hold_now) begin
                sv   = 8;
                reps = 1;
            end
            n = side_in_use(SIDE_W'(sv));
            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 5;
                2:       idle_pct = 20;
                default: idle_pct = 40;
            endcase
            cfg_write(ADDR_SIDE, {26'($urandom()), SIDE_W'(sv)});
            for (int unsigned rep = 0; rep < reps; rep++) begin
                // a write to an unmapped address must leave the frame alone
                if (loops == 0 && rep == 1) cfg_write(ADDR_SPARE, $urandom());
                cnt = n * n;
                if (n > 12)
                    cnt = n * $urandom_range(3, 2) + $urandom_range(n - 1);
                else if (!hold_now && $urandom_range(5) == 0)
                    cnt = $urandom_range(n * n - 1, 1);
                push_frame(n, cnt, t_pattern'($urandom_range(PAT_SPARSE)));
                if (hold_now) hold_req = 1'b1;
                if (cnt < n * n) break;
            end
            settle();
            loops++;
        end

        // first rows of an image at a side above range, no idling
        quiet    = 1'b1;
        idle_pct = 0;
        cfg_write(ADDR_SIDE, DATA_W'(63));
        push_frame(MAX_SIDE, 3 * MAX_SIDE + 5, PAT_NOISE);
        settle();

        $display("%0d pixel beats, %0d result beats, %0d images cut short",
                 n_beats, n_marks, n_aborts);
        $display("sides 2 to 32 incl. clamped writes, back-to-back images, long hold");
        if (errors == 0 && marks_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, marks_due.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
